### hw/rtl/ppdc_pkg.sv
`timescale 1ns / 1ps
package ppdc_pkg;

  localparam int unsigned NumCodes   = 15;
  localparam logic [3:0]  BypassCode = 4'd15;
  localparam logic [29:0] NsPerSec   = 30'd1000000000;
  localparam logic [28:0] NsHalf     = 29'd500000000;

  // Divider for each prescaler code; zero marks an unused code.
  function automatic logic [16:0] divider_of(input logic [3:0] code);
    logic [16:0] d;
    case (code)
      4'd0:    d = 17'd120;
      4'd1:    d = 17'd180;
      4'd2:    d = 17'd240;
      4'd3:    d = 17'd360;
      4'd4:    d = 17'd480;
      4'd8:    d = 17'd12000;
      4'd9:    d = 17'd24000;
      4'd10:   d = 17'd36000;
      4'd11:   d = 17'd48000;
      4'd12:   d = 17'd72000;
      default: d = 17'd0;
    endcase
    return d;
  endfunction

endpackage

### hw/rtl/pwm_prescaler_period_duty_calc.sv
`timescale 1ns / 1ps
// Flow, bypass tried first when on: a multiply and a divide give the count; when the
//   undivided clock fits, a multiply and a divide give duty; each divided code tried
//   adds a divide, 32x32 multiply and divide, unused codes are skipped; a zero period
//   is a range error. One item at a time: a new input waits until the result has left;
//   the bit-serial multiplier and 64-bit restoring divider set the pace.
// Reset: asynchronous active low; registers return to 24 MHz, bypass on.
module pwm_prescaler_period_duty_calc #(
  parameter int unsigned PERIOD_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [30:0] duty_time_ns_i,
  input  logic [30:0] period_time_ns_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  prescaler_code_o,
  output logic [15:0] period_field_o,
  output logic [15:0] duty_field_o,
  output logic        range_error_o
);
  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StBpMul = 9'b000000010,
    StBpDiv = 9'b000000100,
    StTbCk  = 9'b000001000,
    StTbDv1 = 9'b000010000,
    StTbMul = 9'b000100000,
    StTbDv2 = 9'b001000000,
    StDtMul = 9'b010000000,
    StDtDiv = 9'b100000000
  } state_e;

  // Fit limit: count-1 <= 2^PERIOD_BITS - 1.
  localparam logic [63:0] FitLimit = (64'd1 << PERIOD_BITS) - 64'd1;

  state_e      state_q, state_d;
  logic [31:0] clk_rate_q;
  logic        bypass_q;
  logic [30:0] duty_q, period_q;
  logic [3:0]  code_q, code_d;
  logic [63:0] count_q, count_d;

  // Result register.
  logic        out_valid_q;
  logic [3:0]  res_code_q;
  logic [15:0] res_period_q, res_duty_q;
  logic        res_err_q;

  // Shared units.
  logic        mul_start, mul_done;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        div_start, div_done;
  logic [63:0] div_num, div_q;
  logic [31:0] div_den;

  ppdc_serial_mul #(.AW(32), .BW(32)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_p)
  );

  ppdc_serial_div #(.NumW(64), .DenW(32)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_q)
  );

  logic        in_fire, fits;
  logic        fin, fin_err;
  logic [15:0] fin_duty;

  // Hold new items back while a register write is offered; take writes only
  // between items so a calculation never sees its settings change.
  assign in_ready_o  = (state_q == StIdle) && !out_valid_q && !cfg_valid_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = (state_q == StIdle);
  // count - 1 wraps for zero, so zero never fits.
  assign fits        = (div_q - 64'd1) <= FitLimit;

  always_comb begin
    state_d   = state_q;
    code_d    = code_q;
    count_d   = count_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    fin       = 1'b0;
    fin_err   = 1'b0;
    fin_duty  = '0;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          code_d = '0;
          if (period_time_ns_i == '0) begin
            fin     = 1'b1;
            fin_err = 1'b1;
          end else if (bypass_q) begin
            mul_start = 1'b1;
            mul_a     = clk_rate_q;
            mul_b     = {1'b0, period_time_ns_i};
            state_d   = StBpMul;
          end else begin
            state_d = StTbCk;
          end
        end
      end
      StBpMul: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_num   = mul_p + 64'(ppdc_pkg::NsHalf);
          div_den   = 32'(ppdc_pkg::NsPerSec);
          state_d   = StBpDiv;
        end
      end
      StBpDiv: begin
        if (div_done) begin
          if (fits) begin
            count_d   = div_q;
            code_d    = ppdc_pkg::BypassCode;
            mul_start = 1'b1;
            mul_a     = div_q[31:0];
            mul_b     = {1'b0, duty_q};
            state_d   = StDtMul;
          end else begin
            state_d = StTbCk;
          end
        end
      end
      StTbCk: begin
        // Skip unused codes; give up past the last table code.
        if (code_q == 4'(ppdc_pkg::NumCodes)) begin
          fin     = 1'b1;
          fin_err = 1'b1;
          state_d = StIdle;
        end else if (ppdc_pkg::divider_of(code_q) == '0) begin
          code_d = code_q + 4'd1;
        end else begin
          div_start = 1'b1;
          div_num   = 64'(clk_rate_q);
          div_den   = 32'(ppdc_pkg::divider_of(code_q));
          state_d   = StTbDv1;
        end
      end
      StTbDv1: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = div_q[31:0];
          mul_b     = {1'b0, period_q};
          state_d   = StTbMul;
        end
      end
      StTbMul: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_num   = mul_p;
          div_den   = 32'(ppdc_pkg::NsPerSec);
          state_d   = StTbDv2;
        end
      end
      StTbDv2: begin
        if (div_done) begin
          if (fits) begin
            count_d   = div_q;
            mul_start = 1'b1;
            mul_a     = div_q[31:0];
            mul_b     = {1'b0, duty_q};
            state_d   = StDtMul;
          end else begin
            code_d  = code_q + 4'd1;
            state_d = StTbCk;
          end
        end
      end
      StDtMul: begin
        // count <= 2^PERIOD_BITS, so with PERIOD_BITS <= 32 (count * duty) fits 64 bits; a count of
        // 2^32 has low word zero, handle by adding duty<<32.
        if (mul_done) begin
          div_start = 1'b1;
          div_num   = mul_p + (count_q[32] ? {1'b0, duty_q, 32'd0} : 64'd0);
          div_den   = {1'b0, period_q};
          state_d   = StDtDiv;
        end
      end
      StDtDiv: begin
        if (div_done) begin
          fin      = 1'b1;
          fin_duty = div_q[15:0];
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      clk_rate_q  <= 32'd24000000;
      bypass_q    <= 1'b1;
      out_valid_q <= 1'b0;
      code_q      <= '0;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == 1'b0) begin
          clk_rate_q <= cfg_data_i;
        end else begin
          bypass_q <= cfg_data_i[0];
        end
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    if (in_fire) begin
      duty_q   <= duty_time_ns_i;
      period_q <= period_time_ns_i;
    end
    if (fin) begin
      res_err_q    <= fin_err;
      res_code_q   <= fin_err ? 4'd0 : code_q;
      res_period_q <= fin_err ? 16'd0 : 16'(count_q - 64'd1);
      res_duty_q   <= fin_err ? 16'd0 : fin_duty;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign prescaler_code_o = res_code_q;
  assign period_field_o   = res_period_q;
  assign duty_field_o     = res_duty_q;
  assign range_error_o    = res_err_q;

`ifndef SYNTHESIS
  a_busy_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("ready while busy");
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> out_valid_q && state_q == StIdle) else $error("finish lost");
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_err_q) |-> (res_code_q == 4'd0)) else $error("err code");
`endif
endmodule

### hw/rtl/ppdc_serial_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module ppdc_serial_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], quot_q[NumW-1]};
    diff   = trial - {1'b0, den_q};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = diff;
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
  a_no_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q)) else $error("done while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("start lost");
`endif
endmodule

### hw/rtl/ppdc_serial_mul.sv
`timescale 1ns / 1ps
// Shift-add multiplier, one multiplier bit per cycle.
module ppdc_serial_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] prod_o
);
  localparam int unsigned CntW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc_q, acc_d;
  logic [AW-1:0]    a_q, a_d;
  logic [BW-1:0]    b_q, b_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      cnt_d  = CntW'(BW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Walk multiplier bits from MSB down: acc = 2*acc + a*bit.
      acc_d = {acc_q[AW+BW-2:0], 1'b0} + (b_q[BW-1] ? (AW+BW)'(a_q) : '0);
      b_d   = {b_q[BW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
  a_no_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q)) else $error("done while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("start lost");
`endif
endmodule

### test/tb_pwm_prescaler_period_duty_calc.sv
`timescale 1ns / 1ps
module tb_pwm_prescaler_period_duty_calc;

  // Register indexes of the write port.
  localparam logic CfgClockRate = 1'b0;
  localparam logic CfgBypass    = 1'b1;

  localparam int unsigned PeriodBits   = 16;
  localparam int unsigned ItemsPerPhase = 300;
  localparam int unsigned NumPhases     = 6;
  // Allows for the worst-case item time plus stalls on both sides.
  localparam longint unsigned CycleLimit = 64'd20_000_000;

  typedef struct packed {
    logic [3:0]  code;
    logic [15:0] period_field;
    logic [15:0] duty_field;
    logic        range_error;
  } setting_t;

  typedef struct {
    logic [30:0] duty;
    logic [30:0] period;
    logic        typed;
    setting_t    want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [30:0] duty_time_ns_i = '0;
  logic [30:0] period_time_ns_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  prescaler_code_o;
  logic [15:0] period_field_o;
  logic [15:0] duty_field_o;
  logic        range_error_o;

  pwm_prescaler_period_duty_calc u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .duty_time_ns_i, .period_time_ns_i,
    .out_valid_o, .out_ready_i, .prescaler_code_o, .period_field_o,
    .duty_field_o, .range_error_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the block's registers, reset values.
  logic [31:0] clock_hz_q = 32'd24000000;
  logic        bypass_q   = 1'b1;

  setting_t    pending_settings[$];
  int unsigned fail_count;
  int unsigned result_count;
  int unsigned error_results;
  logic [15:0] codes_seen;
  logic        calm;  // no idling on either side in the last phase
  longint unsigned cycle_count;

  // Table dividers, zero marks a code with no divider.
  function automatic logic [63:0] divider_for(input int unsigned code);
    case (code)
      0:  return 64'd120;
      1:  return 64'd180;
      2:  return 64'd240;
      3:  return 64'd360;
      4:  return 64'd480;
      8:  return 64'd12000;
      9:  return 64'd24000;
      10: return 64'd36000;
      11: return 64'd48000;
      12: return 64'd72000;
      default: return 64'd0;
    endcase
  endfunction

  function automatic logic count_in_range(input logic [63:0] cnt);
    // Zero wraps to a huge value and falls out.
    return (cnt - 64'd1) <= ((64'd1 << PeriodBits) - 64'd1);
  endfunction

  // Pick prescaler code and register fields for one request.
  function automatic setting_t pick_setting(input logic [30:0] duty,
                                            input logic [30:0] period);
    setting_t    s;
    logic [63:0] clk64;
    logic [63:0] per64;
    logic [63:0] cnt;
    logic [63:0] div;
    logic [63:0] duty_cnt;
    logic        found;
    s = '0;
    s.range_error = 1'b1;
    clk64 = {32'd0, clock_hz_q};
    per64 = {33'd0, period};
    cnt = '0;
    found = 1'b0;
    if (period == '0) return s;
    if (bypass_q) begin
      cnt = (clk64 * per64 + 64'd500000000) / 64'd1000000000;
      if (count_in_range(cnt)) begin
        s.code = ppdc_pkg::BypassCode;
        found = 1'b1;
      end
    end
    for (int unsigned i = 0; i < ppdc_pkg::NumCodes && !found; i++) begin
      div = divider_for(i);
      if (div != 0) begin
        cnt = (clk64 / div) * per64 / 64'd1000000000;
        if (count_in_range(cnt)) begin
          s.code = i[3:0];
          found = 1'b1;
        end
      end
    end
    if (!found) return s;
    duty_cnt = cnt * {33'd0, duty} / per64;
    s.period_field = cnt[15:0] - 16'd1;
    s.duty_field = duty_cnt[15:0];
    s.range_error = 1'b0;
    return s;
  endfunction

  task automatic idle_gap(output int unsigned gap);
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
  endtask

  // Present one item; valid stays high across back-to-back items.
  task automatic send_item(input logic [30:0] duty, input logic [30:0] period,
                           input logic typed, input setting_t want);
    int unsigned gap;
    idle_gap(gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    duty_time_ns_i <= duty;
    period_time_ns_i <= period;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_settings.push_back(typed ? want : pick_setting(duty, period));
  endtask

  // Offer one register write; the caller drops valid after the last write.
  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgClockRate) clock_hz_q = data;
    else bypass_q = data[0];
  endtask

  // Drain outstanding results, then let the block settle.
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_settings.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic report_field(input string name, input longint unsigned want,
                              input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Randomize stall bursts on the result side.
  int unsigned stall_left;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(0, 10);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each item leaving the block with the oldest pending setting.
  always @(posedge clk_i) begin
    setting_t exp_s;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_settings.size() == 0) begin
        $display("%0t: unexpected result, code %0d period %0d duty %0d error %0d",
                 $time, prescaler_code_o, period_field_o, duty_field_o, range_error_o);
        fail_count++;
      end else begin
        exp_s = pending_settings.pop_front();
        report_field("prescaler_code", exp_s.code, prescaler_code_o);
        report_field("period_field", exp_s.period_field, period_field_o);
        report_field("duty_field", exp_s.duty_field, duty_field_o);
        report_field("range_error", exp_s.range_error, range_error_o);
        result_count++;
        if (exp_s.range_error) error_results++;
        else codes_seen[exp_s.code] = 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_settings.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic stim_row_t mk_row(input logic [30:0] duty,
                                       input logic [30:0] period, input logic typed,
                                       input logic [3:0] code, input logic [15:0] pf,
                                       input logic [15:0] df, input logic err);
    stim_row_t r;
    r.duty = duty;
    r.period = period;
    r.typed = typed;
    r.want = '{code: code, period_field: pf, duty_field: df, range_error: err};
    return r;
  endfunction

  initial begin
    stim_row_t   dir_rows[$];
    logic [30:0] duty;
    logic [30:0] period;
    logic [31:0] mask;
    logic [31:0] clk_sel;
    int unsigned width;

    fail_count = 0;
    result_count = 0;
    error_results = 0;
    codes_seen = '0;
    calm = 1'b0;
    cycle_count = 0;
    stall_left = 0;

    // Directed rows, valid under the reset settings (24 MHz, bypass on).
    dir_rows.push_back(mk_row(31'd0, 31'd0, 1'b1, 4'd0, 16'd0, 16'd0, 1'b1));
    dir_rows.push_back(mk_row(31'h7FFFFFFF, 31'd0, 1'b1, 4'd0, 16'd0, 16'd0, 1'b1));
    // Too short for any divider.
    dir_rows.push_back(mk_row(31'd5, 31'd1, 1'b1, 4'd0, 16'd0, 16'd0, 1'b1));
    dir_rows.push_back(mk_row(31'd500, 31'd1000, 1'b1, ppdc_pkg::BypassCode, 16'd23,
                              16'd12, 1'b0));
    // Shortest period that rounds to a count of one.
    dir_rows.push_back(mk_row(31'd21, 31'd21, 1'b1, ppdc_pkg::BypassCode, 16'd0, 16'd1,
                              1'b0));
    dir_rows.push_back(mk_row(31'h7FFFFFFF, 31'h7FFFFFFF, 1'b0, '0, '0, '0, 1'b0));
    dir_rows.push_back(mk_row(31'd0, 31'h7FFFFFFF, 1'b0, '0, '0, '0, 1'b0));
    // Duty above period, not clamped.
    dir_rows.push_back(mk_row(31'h7FFFFFFF, 31'd1000, 1'b0, '0, '0, '0, 1'b0));
    dir_rows.push_back(mk_row(31'd0, 31'd1000000, 1'b0, '0, '0, '0, 1'b0));
    // Around the top of the bypass range.
    dir_rows.push_back(mk_row(31'd1365322, 31'd2730645, 1'b0, '0, '0, '0, 1'b0));
    dir_rows.push_back(mk_row(31'd1365323, 31'd2730646, 1'b0, '0, '0, '0, 1'b0));
    dir_rows.push_back(mk_row(31'd2730667, 31'd2730667, 1'b0, '0, '0, '0, 1'b0));
    // Steps through the divided codes.
    dir_rows.push_back(mk_row(31'd4000000, 31'd5000000, 1'b0, '0, '0, '0, 1'b0));
    dir_rows.push_back(mk_row(31'd1, 31'd40000000, 1'b0, '0, '0, '0, 1'b0));
    dir_rows.push_back(mk_row(31'h55555555, 31'h2AAAAAAA, 1'b0, '0, '0, '0, 1'b0));
    dir_rows.push_back(mk_row(31'h2AAAAAAA, 31'h55555555, 1'b0, '0, '0, '0, 1'b0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].duty, dir_rows[i].period, dir_rows[i].typed, dir_rows[i].want);

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      drain();
      // Sweep nominal, slowest, fastest, 100 MHz and random clocks with bypass both ways.
      case (ph)
        0: clk_sel = 32'd24000000;
        1: clk_sel = 32'd1;
        2: clk_sel = 32'hFFFFFFFF;
        3: clk_sel = 32'd100000000;
        4: clk_sel = $urandom;
        default: clk_sel = $urandom_range(1000000, 200000000);
      endcase
      write_reg(CfgClockRate, clk_sel);
      write_reg(CfgBypass, {31'd0, (ph % 2 == 0) ? 1'b0 : 1'b1});
      cfg_valid_i <= 1'b0;
      if (ph == NumPhases - 1) calm = 1'b1;
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        // Spread periods over all magnitudes so every code gets reached.
        width = $urandom_range(1, 31);
        mask = (32'd1 << width) - 32'd1;
        period = 31'($urandom) & mask[30:0];
        if ($urandom_range(0, 49) == 0) period = '0;
        if ($urandom_range(0, 3) == 0) duty = 31'($urandom);
        else duty = 31'($urandom % ({1'b0, period} + 32'd1));
        send_item(duty, period, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_settings.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Checked %0d results, %0d of them range errors, over %0d clock settings.",
             result_count, error_results, NumPhases + 1);
    $display("Prescaler codes chosen (bit per code): %b", codes_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/ppdc_pkg.sv
hw/rtl/ppdc_serial_div.sv
hw/rtl/ppdc_serial_mul.sv
hw/rtl/pwm_prescaler_period_duty_calc.sv
test/tb_pwm_prescaler_period_duty_calc.sv
